### rtl/usnp_pkg.sv
`default_nettype none
package usnp_pkg;

  // Widths fixed by the item format
  localparam int CH_W        = 8;
  localparam int OUT_VALUE_W = 63;
  localparam int MULT_W      = 31;
  localparam int ENTRY_N     = 9;
  localparam int VALUE_WIDTH_DEF = 63;

  // Register map
  localparam logic REG_UNIT_TABLE = 1'b0;

  // Table selector codes
  localparam logic [1:0] TBL_BYTES  = 2'd0;
  localparam logic [1:0] TBL_TIME   = 2'd1;
  localparam logic [1:0] TBL_METRIC = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_K = 8'h6b;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_S = 8'h73;

  // Parse phases
  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_DIGIT = 4'b0010,
    PH_MID   = 4'b0100,
    PH_TAIL  = 4'b1000
  } phase_t;

  // One suffix table entry
  typedef struct packed {
    logic [1:0]        len;
    logic [7:0]        l0;
    logic [7:0]        l1;
    logic [7:0]        l2;
    logic [MULT_W-1:0] mult;
  } entry_t;

  // Flags and multiplier of a finished string
  typedef struct packed {
    logic              known;
    logic              ovf;
    logic [MULT_W-1:0] mult;
  } term_t;

  function automatic entry_t mk(input logic [1:0] len, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] c,
                                input logic [MULT_W-1:0] m);
    entry_t e;
    e.len  = len;
    e.l0   = a;
    e.l1   = b;
    e.l2   = c;
    e.mult = m;
    return e;
  endfunction

  function automatic logic [3:0] table_count(input logic [1:0] tbl);
    logic [3:0] n;
    case (tbl)
      TBL_BYTES:  n = 4'd9;
      TBL_TIME:   n = 4'd4;
      TBL_METRIC: n = 4'd3;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic entry_t get_entry(input logic [1:0] tbl, input logic [3:0] idx);
    entry_t e;
    e = mk(2'd0, CH_NUL, CH_NUL, CH_NUL, '0);
    case (tbl)
      TBL_BYTES: begin
        case (idx)
          4'd0:    e = mk(2'd1, CH_K, CH_NUL, CH_NUL, 31'd1024);
          4'd1:    e = mk(2'd2, CH_K, CH_B, CH_NUL, 31'd1024);
          4'd2:    e = mk(2'd3, CH_K, CH_I, CH_B, 31'd1024);
          4'd3:    e = mk(2'd1, CH_M, CH_NUL, CH_NUL, 31'd1048576);
          4'd4:    e = mk(2'd2, CH_M, CH_B, CH_NUL, 31'd1048576);
          4'd5:    e = mk(2'd3, CH_M, CH_I, CH_B, 31'd1048576);
          4'd6:    e = mk(2'd1, CH_G, CH_NUL, CH_NUL, 31'd1073741824);
          4'd7:    e = mk(2'd2, CH_G, CH_B, CH_NUL, 31'd1073741824);
          4'd8:    e = mk(2'd3, CH_G, CH_I, CH_B, 31'd1073741824);
          default: e = mk(2'd0, CH_NUL, CH_NUL, CH_NUL, '0);
        endcase
      end
      TBL_TIME: begin
        case (idx)
          4'd0:    e = mk(2'd1, CH_S, CH_NUL, CH_NUL, 31'd1);
          4'd1:    e = mk(2'd1, CH_M, CH_NUL, CH_NUL, 31'd60);
          4'd2:    e = mk(2'd1, CH_H, CH_NUL, CH_NUL, 31'd3600);
          4'd3:    e = mk(2'd1, CH_D, CH_NUL, CH_NUL, 31'd86400);
          default: e = mk(2'd0, CH_NUL, CH_NUL, CH_NUL, '0);
        endcase
      end
      TBL_METRIC: begin
        case (idx)
          4'd0:    e = mk(2'd1, CH_K, CH_NUL, CH_NUL, 31'd1000);
          4'd1:    e = mk(2'd1, CH_M, CH_NUL, CH_NUL, 31'd1000000);
          4'd2:    e = mk(2'd1, CH_G, CH_NUL, CH_NUL, 31'd1000000000);
          default: e = mk(2'd0, CH_NUL, CH_NUL, CH_NUL, '0);
        endcase
      end
      default: e = mk(2'd0, CH_NUL, CH_NUL, CH_NUL, '0);
    endcase
    return e;
  endfunction

  function automatic logic [7:0] entry_letter(input entry_t e, input logic [1:0] pos);
    logic [7:0] l;
    case (pos)
      2'd0:    l = e.l0;
      2'd1:    l = e.l1;
      2'd2:    l = e.l2;
      default: l = CH_NUL;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

### rtl/unit_suffix_number_parser.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_ch[7:0]
// out       output     out_valid / out_ready out_value[62:0], out_unit_known, out_overflow
// cfg       input      APB, pready high      unit_table at byte 0
//
// One character is taken per cycle while in_ready is high; the state update runs in
// the cycle it is accepted. A terminator's result item passes two registers: the split
// 32x31 and 31x31 partial products, then their sum, saturated, in the output register.
// A full output register stalls the two-stage multiply pipe, and in_ready falls
// only when that pipe cannot move. Reset is synchronous and clears all string state.
module unit_suffix_number_parser #(
  parameter int VALUE_WIDTH = usnp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [usnp_pkg::CH_W-1:0]      in_ch,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [usnp_pkg::OUT_VALUE_W-1:0]    out_value,
  output logic                                out_unit_known,
  output logic                                out_overflow,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [2:0]                     cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic [1:0]             unit_table_r, unit_table_nxt;
  logic                   take, term_take, take_ok;
  logic [VALUE_WIDTH-1:0] term_acc;
  usnp_pkg::term_t        term;

  // Configuration register
  assign cfg_pready = 1'b1;

  always_comb begin
    unit_table_nxt = unit_table_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == usnp_pkg::REG_UNIT_TABLE))
      unit_table_nxt = cfg_pwdata[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_table_r <= usnp_pkg::TBL_BYTES;
    end else begin
      unit_table_r <= unit_table_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == usnp_pkg::REG_UNIT_TABLE) ? {30'd0, unit_table_r} : '0;

  // Accept an item whenever the multiply pipe can move
  assign in_ready = take_ok;
  assign take     = in_valid && in_ready;

  usnp_scan #(.VALUE_WIDTH(VALUE_WIDTH)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .ch         (in_ch),
    .unit_table (unit_table_r),
    .term_take  (term_take),
    .term_acc   (term_acc),
    .term       (term)
  );

  usnp_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .term_take      (term_take),
    .term_acc       (term_acc),
    .term           (term),
    .take_ok        (take_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_unit_known (out_unit_known),
    .out_overflow   (out_overflow)
  );

endmodule
`default_nettype wire

### rtl/usnp_scan.sv
`default_nettype none
module usnp_scan #(
  parameter int VALUE_WIDTH = usnp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic [usnp_pkg::CH_W-1:0]    ch,
  input  wire logic [1:0]                   unit_table,
  output logic                              term_take,
  output logic [VALUE_WIDTH-1:0]            term_acc,
  output usnp_pkg::term_t                   term
);

  localparam int EXT_W = VALUE_WIDTH + 4;

  usnp_pkg::phase_t             phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]       acc_r, acc_nxt;
  logic [usnp_pkg::ENTRY_N-1:0] pend_r, pend_nxt;
  logic [usnp_pkg::ENTRY_N-1:0] conf_r, conf_nxt;
  logic [1:0]                   pos_r, pos_nxt;
  logic                         tail_r, tail_nxt;
  logic                         aovf_r, aovf_nxt;

  logic                         is_term, is_space, is_digit;
  logic [EXT_W-1:0]             acc_ext, acc_x10;
  logic [VALUE_WIDTH-1:0]       acc_dig;
  logic                         dig_sat;
  logic [usnp_pkg::ENTRY_N-1:0] pend_tail, conf_tail, hits;
  logic [7:0]                   low_ch;
  logic [3:0]                   cnt;
  usnp_pkg::entry_t             ent;
  usnp_pkg::entry_t             hit_ent;
  logic                         hit_any;
  logic [usnp_pkg::MULT_W-1:0]  hit_mult;

  assign is_term  = (ch == usnp_pkg::CH_NUL);
  assign is_space = !is_term && (ch <= usnp_pkg::CH_SPACE);
  assign is_digit = (ch >= usnp_pkg::CH_ZERO) && (ch <= usnp_pkg::CH_NINE);
  assign low_ch   = ch | usnp_pkg::CH_SPACE;
  assign cnt      = usnp_pkg::table_count(unit_table);

  // Accumulate one digit: acc*10 + d, saturate at the top
  always_comb begin
    acc_ext = EXT_W'(acc_r);
    acc_x10 = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(ch[3:0]);
    dig_sat = |acc_x10[EXT_W-1:VALUE_WIDTH];
    acc_dig = dig_sat ? {VALUE_WIDTH{1'b1}} : acc_x10[VALUE_WIDTH-1:0];
  end

  // Step every active suffix matcher by one tail character
  always_comb begin
    pend_tail = pend_r;
    conf_tail = conf_r;
    ent       = usnp_pkg::get_entry(unit_table, 4'd0);
    for (int i = 0; i < usnp_pkg::ENTRY_N; i++) begin
      ent = usnp_pkg::get_entry(unit_table, 4'(i));
      if ((4'(i) < cnt) && pend_r[i]) begin
        if (pos_r < ent.len) begin
          if (low_ch != usnp_pkg::entry_letter(ent, pos_r)) pend_tail[i] = 1'b0;
        end else begin
          pend_tail[i] = 1'b0;
          if (ch <= usnp_pkg::CH_SPACE) conf_tail[i] = 1'b1;
        end
      end
    end
  end

  // Pick the first matching entry for the terminator
  always_comb begin
    hits     = pend_r | conf_r;
    hit_any  = 1'b0;
    hit_mult = '0;
    hit_ent  = usnp_pkg::get_entry(unit_table, 4'd0);
    for (int i = usnp_pkg::ENTRY_N - 1; i >= 0; i--) begin
      if ((4'(i) < cnt) && hits[i]) begin
        hit_ent  = usnp_pkg::get_entry(unit_table, 4'(i));
        hit_any  = 1'b1;
        hit_mult = hit_ent.mult;
      end
    end
    term_take  = take && is_term;
    term_acc   = acc_r;
    term.ovf   = aovf_r;
    term.known = !tail_r || hit_any;
    term.mult  = !tail_r ? usnp_pkg::MULT_W'(1) : hit_mult;
  end

  // Next string state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    conf_nxt  = conf_r;
    pos_nxt   = pos_r;
    tail_nxt  = tail_r;
    aovf_nxt  = aovf_r;
    if (take) begin
      if (is_term) begin
        phase_nxt = usnp_pkg::PH_LEAD;
        acc_nxt   = '0;
        pend_nxt  = '1;
        conf_nxt  = '0;
        pos_nxt   = '0;
        tail_nxt  = 1'b0;
        aovf_nxt  = 1'b0;
      end else begin
        case (phase_r)
          usnp_pkg::PH_LEAD, usnp_pkg::PH_DIGIT: begin
            if (is_digit) begin
              acc_nxt   = acc_dig;
              aovf_nxt  = aovf_r || dig_sat;
              phase_nxt = usnp_pkg::PH_DIGIT;
            end else if (is_space) begin
              if (phase_r == usnp_pkg::PH_DIGIT) phase_nxt = usnp_pkg::PH_MID;
            end else begin
              phase_nxt = usnp_pkg::PH_TAIL;
            end
          end
          usnp_pkg::PH_MID: begin
            if (!is_space) phase_nxt = usnp_pkg::PH_TAIL;
          end
          default: ;
        endcase
        // Feed the tail matchers
        if ((phase_nxt == usnp_pkg::PH_TAIL)) begin
          tail_nxt = 1'b1;
          pend_nxt = pend_tail;
          conf_nxt = conf_tail;
          if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= usnp_pkg::PH_LEAD;
      acc_r   <= '0;
      pend_r  <= '1;
      conf_r  <= '0;
      pos_r   <= '0;
      tail_r  <= 1'b0;
      aovf_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      pend_r  <= pend_nxt;
      conf_r  <= conf_nxt;
      pos_r   <= pos_nxt;
      tail_r  <= tail_nxt;
      aovf_r  <= aovf_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/usnp_scale.sv
`default_nettype none
module usnp_scale #(
  parameter int VALUE_WIDTH = usnp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             term_take,
  input  wire logic [VALUE_WIDTH-1:0]           term_acc,
  input  wire usnp_pkg::term_t                  term,
  output logic                                  take_ok,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [usnp_pkg::OUT_VALUE_W-1:0]      out_value,
  output logic                                  out_unit_known,
  output logic                                  out_overflow
);

  localparam int LO_W = (VALUE_WIDTH + 1) / 2;
  localparam int HI_W = VALUE_WIDTH - LO_W;
  localparam int PW   = VALUE_WIDTH + usnp_pkg::MULT_W;

  logic                              v1_r, v1_nxt;
  logic [LO_W+usnp_pkg::MULT_W-1:0]  pl_r;
  logic [HI_W+usnp_pkg::MULT_W-1:0]  ph_r;
  logic                              k1_r, o1_r;

  logic                              v2_r, v2_nxt;
  logic [VALUE_WIDTH-1:0]            val2_r;
  logic                              k2_r, o2_r;

  logic                              adv2, adv1;
  logic [PW-1:0]                     full;
  logic                              prod_sat;

  assign adv2    = !v2_r || out_ready;
  assign adv1    = !v1_r || adv2;
  assign take_ok = adv1;

  // Sum partial products and saturate
  always_comb begin
    full     = PW'(pl_r) + (PW'(ph_r) << LO_W);
    prod_sat = |full[PW-1:VALUE_WIDTH];
  end

  always_comb begin
    v1_nxt = adv1 ? term_take : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Stage one: split product
  always_ff @(posedge clk) begin
    if (adv1 && term_take) begin
      pl_r <= (LO_W+usnp_pkg::MULT_W)'(term_acc[LO_W-1:0]) *
              (LO_W+usnp_pkg::MULT_W)'(term.mult);
      ph_r <= (HI_W+usnp_pkg::MULT_W)'(term_acc[VALUE_WIDTH-1:LO_W]) *
              (HI_W+usnp_pkg::MULT_W)'(term.mult);
      k1_r <= term.known;
      o1_r <= term.ovf;
    end
  end

  // Stage two: hold the result item until taken
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      val2_r <= prod_sat ? {VALUE_WIDTH{1'b1}} : full[VALUE_WIDTH-1:0];
      k2_r   <= k1_r;
      o2_r   <= o1_r || prod_sat;
    end
  end

  assign out_valid      = v2_r;
  assign out_value      = usnp_pkg::OUT_VALUE_W'(val2_r);
  assign out_unit_known = k2_r;
  assign out_overflow   = o2_r;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import usnp_pkg::*;

  // Selector code with no suffixes behind it
  localparam logic [1:0] TBL_EMPTY = 2'd3;
  localparam logic [2:0] UNIT_TABLE_ADDR = {REG_UNIT_TABLE, 2'b00};
  localparam longint unsigned SIZE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SEGMENT_CHARS = 120;
  localparam int SEGMENTS = 12;

  typedef enum logic [1:0] {
    SKIP_LEAD,
    IN_DIGITS,
    SKIP_GAP,
    IN_TAIL
  } scan_phase_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic                   known;
    logic                   ovf;
  } size_result_t;

  // Tracks the string being parsed and queues the size each terminator should produce
  class size_tracker;
    logic [1:0]         unit_sel;
    scan_phase_t        scan;
    longint unsigned    number;
    logic [ENTRY_N-1:0] alive;
    logic [ENTRY_N-1:0] hit;
    int unsigned        pos;
    bit                 tail_seen;
    bit                 number_sat;
    size_result_t       pending_sizes[$];
    int                 errors;
    int                 strings;
    int                 unmatched;
    int                 saturated;

    function new();
      unit_sel  = TBL_BYTES;
      errors    = 0;
      strings   = 0;
      unmatched = 0;
      saturated = 0;
      clear();
    endfunction

    static function int suffix_count(input logic [1:0] sel);
      case (sel)
        TBL_BYTES:  return 9;
        TBL_TIME:   return 4;
        TBL_METRIC: return 3;
        default:    return 0;
      endcase
    endfunction

    // Byte table runs k, kb, kib, then the same for m and g
    static function void suffix_entry(input logic [1:0] sel, input int idx,
                                      output string sfx, output longint unsigned mult);
      string lead;
      lead = "";
      sfx  = "";
      mult = 0;
      case (sel)
        TBL_BYTES: begin
          lead = (idx / 3 == 0) ? "k" : (idx / 3 == 1) ? "m" : "g";
          sfx  = (idx % 3 == 0) ? lead : (idx % 3 == 1) ? {lead, "b"} : {lead, "ib"};
          mult = 64'd1 << (10 * (idx / 3 + 1));
        end
        TBL_TIME: begin
          case (idx)
            0:       begin sfx = "s"; mult = 1;     end
            1:       begin sfx = "m"; mult = 60;    end
            2:       begin sfx = "h"; mult = 3600;  end
            default: begin sfx = "d"; mult = 86400; end
          endcase
        end
        TBL_METRIC: begin
          case (idx)
            0:       begin sfx = "k"; mult = 1000;       end
            1:       begin sfx = "m"; mult = 1000000;    end
            default: begin sfx = "g"; mult = 1000000000; end
          endcase
        end
        default: ;
      endcase
    endfunction

    function void clear();
      scan       = SKIP_LEAD;
      number     = 0;
      alive      = '1;
      hit        = '0;
      pos        = 0;
      tail_seen  = 0;
      number_sat = 0;
    endfunction

    // Saturate the accumulator instead of wrapping
    function void add_digit(input int unsigned d);
      if (number > (SIZE_MAX - d) / 10) begin
        number     = SIZE_MAX;
        number_sat = 1;
      end else begin
        number = number * 10 + d;
      end
    endfunction

    // Advance every live suffix matcher by one character
    function void tail_char(input logic [7:0] c);
      string           sfx;
      longint unsigned mult;
      int              n;
      tail_seen = 1;
      n = suffix_count(unit_sel);
      for (int i = 0; i < n; i++) begin
        if (alive[i]) begin
          suffix_entry(unit_sel, i, sfx, mult);
          if (pos < sfx.len()) begin
            if ((c | CH_SPACE) != sfx[pos]) alive[i] = 1'b0;
          end else begin
            alive[i] = 1'b0;
            if (c <= CH_SPACE) hit[i] = 1'b1;
          end
        end
      end
      if (pos < 3) pos++;
    endfunction

    function void parse_char(input logic [7:0] c);
      size_result_t       r;
      longint unsigned    mult;
      string              sfx;
      logic [ENTRY_N-1:0] cand;
      bit                 known;
      bit                 ovf;
      bit                 digit;
      int                 n;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (c == CH_NUL) begin
        mult  = 0;
        known = 0;
        ovf   = number_sat;
        cand  = alive | hit;
        if (!tail_seen) begin
          mult  = 1;
          known = 1;
        end else begin
          // first entry in table order wins, partial matches included
          n = suffix_count(unit_sel);
          for (int i = 0; i < n; i++) begin
            if (!known && cand[i]) begin
              suffix_entry(unit_sel, i, sfx, mult);
              known = 1;
            end
          end
        end
        r.value = '0;
        if (known && mult != 0) begin
          if (number > SIZE_MAX / mult) begin
            r.value = OUT_VALUE_W'(SIZE_MAX);
            ovf = 1;
          end else begin
            r.value = OUT_VALUE_W'(number * mult);
          end
        end
        r.known = known;
        r.ovf   = ovf;
        pending_sizes.push_back(r);
        strings++;
        if (!known) unmatched++;
        if (ovf) saturated++;
        clear();
        return;
      end
      case (scan)
        SKIP_LEAD: begin
          if (digit) begin
            add_digit(c - CH_ZERO);
            scan = IN_DIGITS;
          end else if (c > CH_SPACE) begin
            scan = IN_TAIL;
            tail_char(c);
          end
        end
        IN_DIGITS: begin
          if (digit) begin
            add_digit(c - CH_ZERO);
          end else if (c <= CH_SPACE) begin
            scan = SKIP_GAP;
          end else begin
            scan = IN_TAIL;
            tail_char(c);
          end
        end
        SKIP_GAP: begin
          // a digit here opens the tail rather than resuming the number
          if (c > CH_SPACE) begin
            scan = IN_TAIL;
            tail_char(c);
          end
        end
        default: tail_char(c);
      endcase
    endfunction

    function void compare_size(input size_result_t got);
      size_result_t want;
      if (pending_sizes.size() == 0) begin
        $error("result item with no string pending: value %0d", got.value);
        errors++;
        return;
      end
      want = pending_sizes.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.known !== want.known) begin
        $error("unit_known: expected %0b, actual %0b", want.known, got.known);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %0b, actual %0b", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [CH_W-1:0]        in_ch;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_VALUE_W-1:0] out_value;
  logic                   out_unit_known;
  logic                   out_overflow;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [2:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  size_tracker sb = new();
  logic [1:0]  cur_table = TBL_BYTES;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          chars_sent = 0;

  unit_suffix_number_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_unit_known (out_unit_known),
    .out_overflow   (out_overflow),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels on the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.parse_char(in_ch);
      if (out_valid && out_ready) sb.compare_size('{out_value, out_unit_known, out_overflow});
    end
  end

  // Drive out_ready; hold it low for a long stretch on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    if (terminate) send_char(CH_NUL);
  endtask

  // Drop valid and wait until every pending size has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_sizes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the table selector, then read it back
  task automatic cfg_write(input logic [1:0] sel);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= UNIT_TABLE_ADDR;
    cfg_pwdata  <= {30'd0, sel};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cur_table   = sel;
    sb.unit_sel = sel;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {30'd0, sel}) begin
      $error("unit_table readback: expected %0d, actual %0d", sel, cfg_prdata);
      sb.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly well-formed number plus suffix strings, some pure noise
  task automatic send_random_string();
    logic [7:0]      q[$];
    logic [7:0]      c;
    string           pool;
    string           sfx;
    longint unsigned mult;
    int              kind;
    int              ndig;
    int              n;
    int              cut;
    pool = "kmgbisdh";
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(1, 32)));
      kind = $urandom_range(0, 99);
      ndig = (kind < 8) ? 0 : (kind < 88) ? $urandom_range(1, 6) : $urandom_range(7, 22);
      repeat (ndig) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range(1, 32)));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // a real suffix, maybe cut short, in mixed case
        n = size_tracker::suffix_count(cur_table);
        if (n == 0)
          size_tracker::suffix_entry(TBL_BYTES, $urandom_range(0, 8), sfx, mult);
        else
          size_tracker::suffix_entry(cur_table, $urandom_range(0, n - 1), sfx, mult);
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sfx.len()) : sfx.len();
        for (int i = 0; i < cut; i++) begin
          c = sfx[i];
          if ($urandom_range(0, 1)) c = c & ~CH_SPACE;
          q.push_back(c);
        end
        if ($urandom_range(0, 2) == 0) begin
          q.push_back(8'($urandom_range(1, 32)));
          repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(1, 255)));
        end else if ($urandom_range(0, 5) == 0) begin
          q.push_back(pool[$urandom_range(0, 7)]);
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 3)) begin
          c = pool[$urandom_range(0, 7)];
          if ($urandom_range(0, 1)) c = c & ~CH_SPACE;
          q.push_back(c);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(33, 255)));
      end
    end
    q.push_back(CH_NUL);
    foreach (q[i]) send_char(q[i]);
  endtask

  initial begin : stimulus
    int target;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_ch       = CH_NUL;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = UNIT_TABLE_ADDR;
    cfg_pwdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 52;
    cfg_write(TBL_BYTES);

    // Directed: empty string, skipped control and space, case folding,
    // middle spaces, digit after the gap, high character
    send_text("", 1);
    send_char(8'h01);
    send_text(" 12KiB", 1);
    send_text("3 m", 1);
    send_text("4 7", 1);
    send_char(8'hFF);
    send_char(CH_NUL);
    // switch tables partway through a string
    send_text("5k", 0);
    settle();
    cfg_write(TBL_TIME);
    send_text("", 1);
    // characters after a confirmed suffix
    send_text("2m x", 1);

    // Random segments, each under one table setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg == SEGMENTS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 36;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests <= hold_requests + 1;
      end
      cfg_write(2'(seg % 4));
      target = chars_sent + SEGMENT_CHARS;
      while (chars_sent < target) send_random_string();
    end
    settle();

    $display("Sent %0d characters forming %0d strings across all four table settings,",
             chars_sent, sb.strings);
    $display("  %0d with unmatched tails and %0d saturated, including a long output stall.",
             sb.unmatched, sb.saturated);
    if (sb.errors == 0 && sb.pending_sizes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### unit_suffix_number_parser.f
rtl/usnp_pkg.sv
rtl/usnp_scan.sv
rtl/usnp_scale.sv
rtl/unit_suffix_number_parser.sv
tb/sv/tb_top.sv
